// ----- rtl/core/jpeg_marker_segment_scanner_defines.svh -----
// Assertion macros used by the scanner top module.
// They expand to nothing when SYNTHESIS is defined.
`ifndef JPEG_MARKER_SEGMENT_SCANNER_DEFINES_SVH
`define JPEG_MARKER_SEGMENT_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked property check with an active-low reset.
`define JMSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scanner assertion failed");

// The condition must never hold at a clock edge.
`define JMSS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `JMSS_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define JMSS_ASSERT(lbl, clk, rst_n, prop)
`define JMSS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/jmss_pkg.sv -----
package jmss_pkg;

  // Scanner phases within the byte stream.
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_CODE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY,
    PH_ENTROPY,
    PH_ENTROPY_FF
  } phase_e;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_MARKER   = 3'd0,
    EV_FRAME    = 3'd1,
    EV_FILL     = 3'd2,
    EV_RESTART  = 3'd3,
    EV_TRAILING = 3'd4,
    EV_NOMARKER = 3'd5,
    EV_RUNAWAY  = 3'd6,
    EV_EOF      = 3'd7
  } event_e;

  // Marker codes and byte values of interest.
  localparam logic [7:0] MK_INVALID = 8'h00;
  localparam logic [7:0] MK_TEM     = 8'h01;
  localparam logic [7:0] MK_SOF_LO  = 8'hC0;
  localparam logic [7:0] MK_DHT     = 8'hC4;
  localparam logic [7:0] MK_JPG     = 8'hC8;
  localparam logic [7:0] MK_DAC     = 8'hCC;
  localparam logic [7:0] MK_SOF_HI  = 8'hCF;
  localparam logic [7:0] MK_RST0    = 8'hD0;
  localparam logic [7:0] MK_RST7    = 8'hD7;
  localparam logic [7:0] MK_SOI     = 8'hD8;
  localparam logic [7:0] MK_EOI     = 8'hD9;
  localparam logic [7:0] MK_SOS     = 8'hDA;
  localparam logic [7:0] MK_DHP     = 8'hDE;
  localparam logic [7:0] MK_CODE_HI = 8'hFE;
  localparam logic [7:0] MK_FILL    = 8'hFF;

  // Up to three results per byte.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = 2;
  localparam int unsigned BODY_FIELDS = 6;

  typedef struct packed {
    phase_e      phase;
    logic        image_ended;
    logic        scan_stopped;
    logic [7:0]  current_marker;
    logic [7:0]  length_high;
    logic [15:0] bytes_left;
    logic [2:0]  body_index;
    logic [7:0]  held_precision;
    logic [15:0] held_height;
    logic [15:0] held_width;
    logic [7:0]  held_components;
  } scan_state_t;

  typedef struct packed {
    event_e     ev;
    logic [7:0] marker;
  } result_t;

  // All results caused by one byte, plus the frame fields they may carry.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0]          count;
    logic [7:0]                precision;
    logic [15:0]               height;
    logic [15:0]               width;
    logic [7:0]                components;
  } bundle_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:           PH_PREFIX,
    image_ended:     1'b0,
    scan_stopped:    1'b0,
    current_marker:  8'h00,
    length_high:     8'h00,
    bytes_left:      16'h0000,
    body_index:      3'd0,
    held_precision:  8'h00,
    held_height:     16'h0000,
    held_width:      16'h0000,
    held_components: 8'h00
  };

endpackage

// ----- rtl/core/jmss_if.sv -----
// Byte channel into the scanner.
interface jmss_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// Result channel out of the scanner.
interface jmss_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_code;
  logic [7:0]  marker_code;
  logic [7:0]  sample_precision;
  logic [15:0] image_height;
  logic [15:0] image_width;
  logic [7:0]  component_count;
  logic        run_end;

  modport source (
    output valid, output event_code, output marker_code, output sample_precision,
    output image_height, output image_width, output component_count, output run_end,
    input ready
  );
  modport sink (
    input valid, input event_code, input marker_code, input sample_precision,
    input image_height, input image_width, input component_count, input run_end,
    output ready
  );
endinterface

// ----- rtl/core/jmss_step.sv -----
module jmss_step (
  input  jmss_pkg::scan_state_t state_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  final_byte_i,
  output jmss_pkg::scan_state_t state_d_o,
  output jmss_pkg::bundle_t     bundle_o
);
  import jmss_pkg::*;

  // Append one result to the bundle while there is room.
  function automatic bundle_t push(input bundle_t bd, input event_e ev, input logic [7:0] mk);
    bundle_t r;
    r = bd;
    if (r.count < CNT_W'(MAX_RESULTS)) begin
      r.res[r.count] = '{ev: ev, marker: mk};
      r.count = r.count + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic logic is_rst(input logic [7:0] m);
    return (m >= MK_RST0) && (m <= MK_RST7);
  endfunction

  // Frame headers: SOF codes other than DHT, JPG and DAC, plus DHP.
  function automatic logic is_frame(input logic [7:0] m);
    return (m == MK_DHP) ||
           ((m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
            (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC));
  endfunction

  scan_state_t nx;
  bundle_t     bd;
  logic [15:0] seg_len;
  logic [15:0] left;
  logic        do_code;
  logic        do_finish;
  logic [7:0]  b;
  logic        fin;

  assign b   = data_byte_i;
  assign fin = final_byte_i;

  always_comb begin
    nx        = state_i;
    bd        = '0;
    do_code   = 1'b0;
    do_finish = 1'b0;
    seg_len   = {state_i.length_high, b};
    left      = state_i.bytes_left - 16'd1;

    // Per-phase handling of the byte.
    if (!state_i.scan_stopped) begin
      case (state_i.phase)
        PH_PREFIX: begin
          if (!fin) begin
            if (b != MK_FILL) begin
              if (!nx.image_ended) bd = push(bd, EV_NOMARKER, b);
              nx.scan_stopped = 1'b1;
            end else begin
              nx.phase = PH_CODE;
            end
          end
        end
        PH_CODE: begin
          do_code = 1'b1;
        end
        PH_LEN_HI: begin
          nx.length_high = b;
          nx.phase       = PH_LEN_LO;
          if (fin) begin
            bd = push(bd, EV_RUNAWAY, nx.current_marker);
            nx.scan_stopped = 1'b1;
          end
        end
        PH_LEN_LO: begin
          if (seg_len < 16'd2) begin
            bd = push(bd, EV_RUNAWAY, nx.current_marker);
            nx.scan_stopped = 1'b1;
          end else begin
            nx.bytes_left      = seg_len - 16'd2;
            nx.body_index      = 3'd0;
            nx.held_precision  = 8'h00;
            nx.held_height     = 16'h0000;
            nx.held_width      = 16'h0000;
            nx.held_components = 8'h00;
            if (nx.bytes_left == 16'd0) begin
              do_finish = 1'b1;
            end else if (fin) begin
              bd = push(bd, EV_RUNAWAY, nx.current_marker);
              nx.scan_stopped = 1'b1;
            end else begin
              nx.phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          // Capture the leading frame header bytes.
          case (state_i.body_index)
            3'd0:    nx.held_precision    = b;
            3'd1:    nx.held_height[15:8] = b;
            3'd2:    nx.held_height[7:0]  = b;
            3'd3:    nx.held_width[15:8]  = b;
            3'd4:    nx.held_width[7:0]   = b;
            3'd5:    nx.held_components   = b;
            default: ;
          endcase
          if (state_i.body_index < 3'(BODY_FIELDS)) nx.body_index = state_i.body_index + 3'd1;
          nx.bytes_left = left;
          if (left == 16'd0) begin
            do_finish = 1'b1;
          end else if (fin) begin
            bd = push(bd, EV_RUNAWAY, nx.current_marker);
            nx.scan_stopped = 1'b1;
          end
        end
        PH_ENTROPY: begin
          if (b == MK_FILL) nx.phase = PH_ENTROPY_FF;
        end
        PH_ENTROPY_FF: begin
          if ((b >= MK_SOF_LO) && (b <= MK_CODE_HI) && !is_rst(b)) begin
            do_code = 1'b1;
          end else if (b != MK_FILL) begin
            nx.phase = PH_ENTROPY;
          end
        end
        default: begin
          if (!nx.image_ended) bd = push(bd, EV_NOMARKER, b);
          nx.scan_stopped = 1'b1;
        end
      endcase

      // Marker code following a prefix.
      if (do_code) begin
        if (b == MK_INVALID) begin
          if (!nx.image_ended) bd = push(bd, EV_NOMARKER, b);
          nx.scan_stopped = 1'b1;
        end else if (b == MK_FILL) begin
          bd = push(bd, EV_FILL, MK_FILL);
          nx.phase = PH_CODE;
        end else begin
          bd = push(bd, EV_MARKER, b);
          nx.current_marker = b;
          nx.image_ended    = (b == MK_EOI);
          if (is_rst(b)) begin
            bd = push(bd, EV_RESTART, b);
            nx.phase = PH_PREFIX;
          end else if (b == MK_EOI) begin
            if (!fin) bd = push(bd, EV_TRAILING, MK_EOI);
            nx.phase = PH_PREFIX;
          end else if ((b == MK_SOI) || (b == MK_TEM)) begin
            nx.phase = PH_PREFIX;
          end else begin
            nx.phase = PH_LEN_HI;
            if (fin) begin
              bd = push(bd, EV_RUNAWAY, nx.current_marker);
              nx.scan_stopped = 1'b1;
            end
          end
        end
      end

      // End of a segment body.
      if (do_finish) begin
        if (is_frame(nx.current_marker)) bd = push(bd, EV_FRAME, nx.current_marker);
        nx.phase = (nx.current_marker == MK_SOS) ? PH_ENTROPY : PH_PREFIX;
      end

      // File ends outside a segment without an EOI.
      if (fin && !nx.scan_stopped && !nx.image_ended &&
          ((nx.phase == PH_PREFIX) || (nx.phase == PH_CODE) ||
           (nx.phase == PH_ENTROPY) || (nx.phase == PH_ENTROPY_FF))) begin
        bd = push(bd, EV_EOF, 8'h00);
      end
    end

    bd.precision  = nx.held_precision;
    bd.height     = nx.held_height;
    bd.width      = nx.held_width;
    bd.components = nx.held_components;
  end

  // The final byte of a file returns the scanner to its reset state.
  assign state_d_o = fin ? SCAN_RESET : nx;
  assign bundle_o  = bd;

endmodule

// ----- rtl/core/jmss_serializer.sv -----
module jmss_serializer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  jmss_pkg::bundle_t     bundle_i,
  jmss_result_if.source         out_o,
  output logic                  space_o
);
  import jmss_pkg::*;

  bundle_t          bd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             last;
  logic             out_fire;
  result_t          cur;

  assign cur      = bd_q.res[idx_q];
  assign last     = (idx_q == (cnt_q - CNT_W'(1)));
  assign out_fire = out_o.valid && out_o.ready;

  // Room for a new bundle once the stored one is empty or its last result leaves.
  assign space_o = (cnt_q == '0) || (out_o.ready && last);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = bundle_i.count;
      idx_d = '0;
    end else if (out_fire) begin
      if (last) cnt_d = '0;
      else      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load_i) bd_q <= bundle_i;
  end

  // Frame fields show only on a frame info result.
  assign out_o.valid            = (cnt_q != '0);
  assign out_o.event_code       = cur.ev;
  assign out_o.marker_code      = cur.marker;
  assign out_o.sample_precision = (cur.ev == EV_FRAME) ? bd_q.precision  : 8'h00;
  assign out_o.image_height     = (cur.ev == EV_FRAME) ? bd_q.height     : 16'h0000;
  assign out_o.image_width      = (cur.ev == EV_FRAME) ? bd_q.width      : 16'h0000;
  assign out_o.component_count  = (cur.ev == EV_FRAME) ? bd_q.components : 8'h00;
  assign out_o.run_end          = last;

endmodule

// ----- rtl/core/jpeg_marker_segment_scanner.sv -----
// JPEG marker segment scanner. Bytes of a JPEG file enter on in_i, one per
// transaction, with final_byte set on the last byte of each file; marker events,
// frame header info and warnings or errors leave on out_o, one result per
// transaction, with run_end marking the last result caused by a byte. A byte
// is decoded in the cycle it is accepted and its zero to three results are held
// in a result register that delivers one result per cycle while out_o is ready.
// A new byte is accepted only once the register is empty or in the cycle its
// last result is taken. The state resets itself after every final byte.
`include "jpeg_marker_segment_scanner_defines.svh"

module jpeg_marker_segment_scanner (
  input  logic          clk_i,
  input  logic          rst_ni,
  jmss_byte_if.sink     in_i,
  jmss_result_if.source out_o
);
  import jmss_pkg::*;

  scan_state_t state_q, state_d;
  bundle_t     bundle;
  logic        space;
  logic        in_fire;

  assign in_i.ready = space;
  assign in_fire    = in_i.valid && in_i.ready;

  jmss_step u_step (
    .state_i      (state_q),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .state_d_o    (state_d),
    .bundle_o     (bundle)
  );

  // Scanner state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_RESET;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  jmss_serializer u_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_fire),
    .bundle_i (bundle),
    .out_o    (out_o),
    .space_o  (space)
  );

  // A stopped scan gives no results on any byte, the final byte included.
  `JMSS_ASSERT(a_stopped_silent, clk_i, rst_ni,
    (in_fire && state_q.scan_stopped) |-> (bundle.count == '0))
  // The final byte leaves the scanner in its reset state.
  `JMSS_ASSERT(a_final_resets, clk_i, rst_ni,
    (in_fire && in_i.final_byte) |=> (state_q == SCAN_RESET))
  // After the last result of a byte leaves, new results need a new byte.
  `JMSS_ASSERT(a_no_phantom_results, clk_i, rst_ni,
    (out_o.valid && out_o.ready && out_o.run_end) |=> (!out_o.valid || $past(in_fire)))

endmodule
